/* hw/rtl/shtl_pkg.sv */
package shtl_pkg;

	// Fixed field widths
	localparam int NAME_W      = 64;
	localparam int NAME_BYTES  = 8;
	localparam int SUM_W       = 11;
	localparam int STATUS_W    = 2;
	localparam int OUT_IDX_W   = 8;
	localparam int OUT_DATA_W  = 16;

	// Default sizing
	localparam int DEF_NAME_CHARS   = 8;
	localparam int DEF_BUCKETS      = 64;
	localparam int DEF_POOL_ENTRIES = 256;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_FOUND   = 2'd0,
		STAT_CREATED = 2'd1,
		STAT_ABSENT  = 2'd2,
		STAT_FULL    = 2'd3
	} status_t;

	// Lookup sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_HEAD,
		S_WALK
	} fsm_t;

endpackage

/* hw/rtl/symbol_hash_table_lookup_insert.sv */
// Symbol hash table with lookup and optional insert.
// Input channel s_axis: one transaction per name; tdata carries the eight
// name bytes (first character lowest), tuser the create flag. Output channel
// m_axis: one transaction per name with status and pool index.
// Operation: the byte sum of the name selects a bucket; the bucket head and
// then each chain entry are read from synchronous memories, one
// entry per cycle. A miss with create set writes the new entry and relinks
// the head in the cycle the result is registered.
// Sequencing: for an empty bucket the result is registered straight after the
// head read; each chain entry visited adds one entry read before it. The next
// name is accepted the cycle after the result is registered, so one name is
// handled at a time, and the chain walk through the entry memory read port
// dominates the time per name.
// Reset: all bucket heads are swept to empty, one per cycle; s_axis_tready
// stays low during the sweep. The pool count clears.
// Stall: a result waits in the output register while m_axis_tready is low;
// a lookup that finishes meanwhile holds its state until the register frees.
module symbol_hash_table_lookup_insert import shtl_pkg::*; #(
	parameter int NAME_CHARS   = DEF_NAME_CHARS,
	parameter int BUCKETS      = DEF_BUCKETS,
	parameter int POOL_ENTRIES = DEF_POOL_ENTRIES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [NAME_W-1:0]     s_axis_tdata,  // name_bytes[63:0]
	input  logic                  s_axis_tuser,  // create_if_absent
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata   // status[1:0], entry_index[9:2], zero[15:10]
);

	localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int IDX_W  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
	localparam int CNT_W  = $clog2(POOL_ENTRIES + 1);
	localparam int LINK_W = IDX_W + 1;
	localparam int WORD_W = NAME_W + LINK_W;

	fsm_t state_q, state_nxt;

	logic [NAME_W-1:0]   name_m;
	logic [BKT_W-1:0]    bucket;
	logic [NAME_W-1:0]   name_q;
	logic                create_q;
	logic [BKT_W-1:0]    bucket_q;
	logic [IDX_W-1:0]    cur_idx_q;
	logic [CNT_W-1:0]    used_q;

	logic                head_clr_busy;
	logic [LINK_W-1:0]   head_rdata;
	logic                head_rd_en;
	logic [WORD_W-1:0]   entry_rdata;
	logic                entry_rd_en;
	logic [IDX_W-1:0]    entry_rd_addr;

	logic                accept;
	logic                out_free;
	logic                finish;
	logic                do_insert;
	logic                pool_full;
	status_t             fin_status;
	logic [IDX_W-1:0]    fin_idx;

	logic                m_valid_q;
	status_t             m_status_q;
	logic [OUT_IDX_W-1:0] m_idx_q;

	logic                h_valid;
	logic [IDX_W-1:0]    h_idx;
	logic [NAME_W-1:0]   e_name;
	logic                e_next_valid;
	logic [IDX_W-1:0]    e_next_idx;

	assign h_valid      = head_rdata[IDX_W];
	assign h_idx        = head_rdata[IDX_W-1:0];
	assign e_name       = entry_rdata[NAME_W-1:0];
	assign e_next_idx   = entry_rdata[NAME_W +: IDX_W];
	assign e_next_valid = entry_rdata[NAME_W + IDX_W];

	assign s_axis_tready = (state_q == S_IDLE) && !head_clr_busy;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign pool_full     = (used_q == CNT_W'(POOL_ENTRIES));

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - OUT_IDX_W - STATUS_W){1'b0}}, m_idx_q, m_status_q};

	shtl_bucket_hash #(
		.NAME_CHARS(NAME_CHARS),
		.BUCKETS   (BUCKETS),
		.BKT_W     (BKT_W)
	) u_hash (
		.name_bytes(s_axis_tdata),
		.name_m    (name_m),
		.bucket    (bucket)
	);

	shtl_head_store #(
		.BUCKETS(BUCKETS),
		.BKT_W  (BKT_W),
		.LINK_W (LINK_W)
	) u_heads (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (head_rd_en),
		.rd_addr (bucket),
		.rd_data (head_rdata),
		.wr_en   (do_insert),
		.wr_addr (bucket_q),
		.wr_data ({1'b1, used_q[IDX_W-1:0]}),
		.clr_busy(head_clr_busy)
	);

	shtl_entry_store #(
		.POOL_ENTRIES(POOL_ENTRIES),
		.IDX_W       (IDX_W),
		.WORD_W      (WORD_W)
	) u_entries (
		.clk    (clk),
		.rd_en  (entry_rd_en),
		.rd_addr(entry_rd_addr),
		.rd_data(entry_rdata),
		.wr_en  (do_insert),
		.wr_addr(used_q[IDX_W-1:0]),
		.wr_data({h_valid, h_idx, name_q})
	);

	// Sequencer outputs: memory reads, result and insert
	always_comb begin
		head_rd_en    = 1'b0;
		entry_rd_en   = 1'b0;
		entry_rd_addr = h_idx;
		finish        = 1'b0;
		fin_status    = STAT_ABSENT;
		fin_idx       = '0;
		do_insert     = 1'b0;
		case (state_q)
			S_IDLE: begin
				head_rd_en = accept;
			end
			S_HEAD: begin
				if (h_valid) begin
					entry_rd_en   = 1'b1;
					entry_rd_addr = h_idx;
				end else begin
					finish = 1'b1;
				end
			end
			S_WALK: begin
				if (e_name == name_q) begin
					finish     = 1'b1;
					fin_status = STAT_FOUND;
					fin_idx    = cur_idx_q;
				end else if (e_next_valid) begin
					entry_rd_en   = 1'b1;
					entry_rd_addr = e_next_idx;
				end else begin
					finish = 1'b1;
				end
			end
			default: begin
				finish = 1'b0;
			end
		endcase
		// Resolve a miss at the end of the chain
		if (finish && fin_status != STAT_FOUND) begin
			if (!create_q) begin
				fin_status = STAT_ABSENT;
			end else if (pool_full) begin
				fin_status = STAT_FULL;
			end else begin
				fin_status = STAT_CREATED;
				fin_idx    = used_q[IDX_W-1:0];
				do_insert  = out_free;
			end
		end
	end

	// Sequencer next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nxt = S_HEAD;
				end
			end
			S_HEAD, S_WALK: begin
				if (entry_rd_en) begin
					state_nxt = S_WALK;
				end else if (finish && out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Advance state and pool count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (do_insert) begin
				used_q <= used_q + 1'b1;
			end
		end
	end

	// Capture the request and track the entry being read
	always_ff @(posedge clk) begin
		if (accept) begin
			name_q   <= name_m;
			create_q <= s_axis_tuser;
			bucket_q <= bucket;
		end
		if (entry_rd_en) begin
			cur_idx_q <= entry_rd_addr;
		end
	end

	// Output register: load on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (finish && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish && out_free) begin
			m_status_q <= fin_status;
			m_idx_q    <= OUT_IDX_W'(fin_idx);
		end
	end

	// The pool only grows, by one, together with a created result
	assert property (@(posedge clk) disable iff (!arst_n)
		(used_q != $past(used_q)) |->
		(used_q == $past(used_q) + 1'b1 && m_valid_q && m_status_q == STAT_CREATED))
		else $error("pool count changed without a created result");

	// No transaction accepted during the head sweep
	assert property (@(posedge clk) disable iff (!arst_n)
		head_clr_busy |-> !s_axis_tready)
		else $error("input accepted while heads are being cleared");

	// An accepted name moves on to the head read
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_HEAD)
		else $error("accepted name did not start a head read");

	// A new result comes only from a lookup in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q) != S_IDLE)
		else $error("result registered without a lookup");

	// A created result never exceeds the pool
	assert property (@(posedge clk) disable iff (!arst_n)
		do_insert |-> !pool_full && create_q)
		else $error("insert with full pool or without create");

endmodule

/* hw/rtl/shtl_bucket_hash.sv */
module shtl_bucket_hash import shtl_pkg::*; #(
	parameter int NAME_CHARS = DEF_NAME_CHARS,
	parameter int BUCKETS    = DEF_BUCKETS,
	parameter int BKT_W      = $clog2(DEF_BUCKETS)
) (
	input  logic [NAME_W-1:0] name_bytes,
	output logic [NAME_W-1:0] name_m,
	output logic [BKT_W-1:0]  bucket
);

	logic [SUM_W-1:0] sum;

	// Keep the used bytes and add them up
	always_comb begin
		sum    = '0;
		name_m = '0;
		for (int i = 0; i < NAME_BYTES; i++) begin
			if (i < NAME_CHARS) begin
				name_m[8*i +: 8] = name_bytes[8*i +: 8];
				sum = sum + SUM_W'(name_bytes[8*i +: 8]);
			end
		end
		bucket = BKT_W'(sum & SUM_W'(BUCKETS - 1));
	end

endmodule

/* hw/rtl/shtl_head_store.sv */
module shtl_head_store import shtl_pkg::*; #(
	parameter int BUCKETS = DEF_BUCKETS,
	parameter int BKT_W   = $clog2(DEF_BUCKETS),
	parameter int LINK_W  = $clog2(DEF_POOL_ENTRIES) + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [BKT_W-1:0]  rd_addr,
	output logic [LINK_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [BKT_W-1:0]  wr_addr,
	input  logic [LINK_W-1:0] wr_data,
	output logic              clr_busy
);

	logic [LINK_W-1:0] mem [BUCKETS];
	logic [BKT_W-1:0]  clr_addr_q;
	logic              clr_busy_q;

	assign clr_busy = clr_busy_q;

	// Sweep all heads to empty after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == BKT_W'(BUCKETS - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Write port, clear sweep has priority
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read, held between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hw/rtl/shtl_entry_store.sv */
module shtl_entry_store import shtl_pkg::*; #(
	parameter int POOL_ENTRIES = DEF_POOL_ENTRIES,
	parameter int IDX_W        = $clog2(DEF_POOL_ENTRIES),
	parameter int WORD_W       = NAME_W + $clog2(DEF_POOL_ENTRIES) + 1
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [IDX_W-1:0]  rd_addr,
	output logic [WORD_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  logic [WORD_W-1:0] wr_data
);

	logic [WORD_W-1:0] mem [POOL_ENTRIES];

	// Store name and next link together
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read, held between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* tb/sv/tb_symbol_hash_table_lookup_insert.sv */
`timescale 1ns / 100ps

module tb_symbol_hash_table_lookup_insert;
	import shtl_pkg::*;

	localparam int CHARS          = DEF_NAME_CHARS;
	localparam int BUCKET_COUNT   = DEF_BUCKETS;
	localparam int POOL_SIZE      = DEF_POOL_ENTRIES;
	localparam int RANDOM_PER_PHASE = 570;
	localparam int HOLD_AT_RESULT = 1300;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES   = 40;
	localparam logic [NAME_W-1:0] NAME_KEEP =
		(CHARS >= 8) ? {NAME_W{1'b1}} : ((64'd1 << (8 * CHARS)) - 64'd1);

	typedef struct {
		status_t        status;
		logic [7:0]     index;
	} table_answer_t;

	typedef struct {
		logic [NAME_W-1:0] name;
		logic              create;
		logic              typed;
		status_t           status;
		logic [7:0]        index;
	} directed_row_t;

	typedef struct {
		logic valid;
		int   index;
	} chain_link_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [NAME_W-1:0]     s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// Shadow copy of the table contents
	chain_link_t       bucket_link [BUCKET_COUNT];
	logic [NAME_W-1:0] pool_name [POOL_SIZE];
	chain_link_t       pool_link [POOL_SIZE];
	int                pool_taken = 0;
	logic [NAME_W-1:0] known_names [$];

	table_answer_t expected_answers [$];
	int error_count = 0;
	int results_seen = 0;
	int send_idle_pct = 19;
	int recv_idle_pct = 75;

	// Empty table, bucket 0 then bucket 56 for all ones, chains built from
	// byte permutations and from sums that wrap onto bucket 0
	directed_row_t directed_rows [0:14] = '{
		'{64'h0,                  1'b0, 1'b1, STAT_ABSENT,  8'd0},
		'{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, STAT_ABSENT,  8'd0},
		'{64'h0,                  1'b1, 1'b1, STAT_CREATED, 8'd0},
		'{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, STAT_CREATED, 8'd1},
		'{64'h0,                  1'b0, 1'b1, STAT_FOUND,   8'd0},
		'{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, STAT_FOUND,   8'd1},
		'{64'h6261,               1'b1, 1'b0, STAT_FOUND,   8'd0},
		'{64'h6162,               1'b1, 1'b0, STAT_FOUND,   8'd0},
		'{64'h6261,               1'b0, 1'b0, STAT_FOUND,   8'd0},
		'{64'h40,                 1'b1, 1'b0, STAT_FOUND,   8'd0},
		'{64'h0,                  1'b0, 1'b0, STAT_FOUND,   8'd0},
		'{64'h80,                 1'b0, 1'b0, STAT_FOUND,   8'd0},
		'{64'h8000_0000_0000_0000, 1'b1, 1'b0, STAT_FOUND,   8'd0},
		'{64'h1,                  1'b1, 1'b0, STAT_FOUND,   8'd0},
		'{64'h6463,               1'b0, 1'b0, STAT_FOUND,   8'd0}
	};

	symbol_hash_table_lookup_insert i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // name_bytes[63:0]
		.s_axis_tuser  (s_axis_tuser),   // create_if_absent
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)    // status[1:0], entry_index[9:2], zero[15:10]
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Walk the bucket chain, insert at the head on a miss with create set
	function automatic table_answer_t lookup_or_insert(input logic [NAME_W-1:0] raw,
			input logic create);
		logic [NAME_W-1:0] name;
		int unsigned       byte_sum;
		int                bucket;
		chain_link_t       cur;
		int                guard;
		table_answer_t     answer;
		name = raw & NAME_KEEP;
		byte_sum = 0;
		for (int i = 0; i < CHARS && i < 8; i++)
			byte_sum += name[8*i +: 8];
		bucket = byte_sum & (BUCKET_COUNT - 1);
		cur = bucket_link[bucket];
		guard = 0;
		while (cur.valid && cur.index < POOL_SIZE && guard < POOL_SIZE) begin
			if (pool_name[cur.index] == name) begin
				answer.status = STAT_FOUND;
				answer.index  = cur.index[7:0];
				return answer;
			end
			cur = pool_link[cur.index];
			guard++;
		end
		answer.index = 8'd0;
		if (!create) begin
			answer.status = STAT_ABSENT;
		end else if (pool_taken >= POOL_SIZE) begin
			answer.status = STAT_FULL;
		end else begin
			pool_name[pool_taken] = name;
			pool_link[pool_taken] = bucket_link[bucket];
			bucket_link[bucket].valid = 1'b1;
			bucket_link[bucket].index = pool_taken;
			answer.status = STAT_CREATED;
			answer.index  = pool_taken[7:0];
			known_names.push_back(name);
			pool_taken++;
		end
		return answer;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		error_count++;
	endtask

	// Offer one lookup, hold it until accepted, then record its answer
	task automatic send_lookup(input logic [NAME_W-1:0] name, input logic create,
			input logic typed, input table_answer_t typed_answer);
		table_answer_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= name;
		s_axis_tuser  <= create;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predicted = lookup_or_insert(name, create);
		expected_answers.push_back(typed ? typed_answer : predicted);
	endtask

	function automatic logic [NAME_W-1:0] short_text_name();
		logic [NAME_W-1:0] name;
		int                len;
		name = '0;
		len = $urandom_range(8, 1);
		for (int i = 0; i < len; i++)
			name[8*i +: 8] = 8'($urandom_range(126, 33));
		return name;
	endfunction

	// Mostly names already stored or chain neighbors, some fresh and noise
	task automatic send_random_lookup();
		logic [NAME_W-1:0] name;
		logic              create;
		int                pick;
		table_answer_t     unused;
		pick = $urandom_range(99);
		unused.status = STAT_FOUND;
		unused.index  = 8'd0;
		create = 1'($urandom_range(1));
		if (pick < 40) begin
			name = known_names[$urandom_range(known_names.size() - 1)];
		end else if (pick < 65) begin
			name = ($urandom_range(1) != 0) ? short_text_name() : {$urandom, $urandom};
			create = 1'b1;
		end else if (pick < 75) begin
			name = short_text_name();
			create = 1'b0;
		end else if (pick < 90) begin
			// rotate the bytes: same sum, same bucket, different name
			name = known_names[$urandom_range(known_names.size() - 1)];
			name = {name[55:0], name[63:56]};
		end else begin
			name = {$urandom, $urandom};
		end
		send_lookup(name, create, 1'b0, unused);
	endtask

	// Result side: check each transaction, stall at random, one long hold
	initial begin : result_side
		table_answer_t want;
		int            hold_left;
		hold_left = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (expected_answers.size() == 0) begin
					report_mismatch($sformatf("result %h with nothing pending", m_axis_tdata));
				end else begin
					want = expected_answers.pop_front();
					if (status_t'(m_axis_tdata[1:0]) != want.status)
						report_mismatch($sformatf("result %0d status %0d, want %0d",
							results_seen, m_axis_tdata[1:0], want.status));
					if (m_axis_tdata[9:2] != want.index)
						report_mismatch($sformatf("result %0d index %0d, want %0d",
							results_seen, m_axis_tdata[9:2], want.index));
					if (m_axis_tdata[15:10] != '0)
						report_mismatch($sformatf("result %0d pad bits %h",
							results_seen, m_axis_tdata[15:10]));
				end
				results_seen++;
				if (results_seen == HOLD_AT_RESULT)
					hold_left = RX_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Stimulus and end of run
	initial begin : stimulus
		table_answer_t typed_answer;
		for (int b = 0; b < BUCKET_COUNT; b++)
			bucket_link[b] = '{1'b0, 0};
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		arst_n        <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r]) begin
			typed_answer.status = directed_rows[r].status;
			typed_answer.index  = directed_rows[r].index;
			send_lookup(directed_rows[r].name, directed_rows[r].create,
				directed_rows[r].typed, typed_answer);
		end

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 19;
					recv_idle_pct = 75;
				end
				1: begin
					send_idle_pct = 75;
					recv_idle_pct = 19;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			// drop valid and wait for every pending answer between phases
			if (phase > 0) begin
				s_axis_tvalid <= 1'b0;
				while (expected_answers.size() != 0)
					@(posedge clk);
			end
			repeat (RANDOM_PER_PHASE)
				send_random_lookup();
		end

		s_axis_tvalid <= 1'b0;
		while (expected_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_answers.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/shtl_pkg.sv
hw/rtl/shtl_bucket_hash.sv
hw/rtl/shtl_head_store.sv
hw/rtl/shtl_entry_store.sv
hw/rtl/symbol_hash_table_lookup_insert.sv
tb/sv/tb_symbol_hash_table_lookup_insert.sv
